FILE: design/wildcard_byte_pattern_scan_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the wildcard byte pattern scanner
// ---------------------------------------------------------------------------
`ifndef WILDCARD_BYTE_PATTERN_SCAN_DEFINES_SVH
`define WILDCARD_BYTE_PATTERN_SCAN_DEFINES_SVH

// Same-cycle implication, quiet while reset is asserted
`define WBPS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("wbps check failed");

// Next-cycle implication, quiet while reset is asserted
`define WBPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("wbps check failed");

`endif

FILE: design/wbps_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wbps_pkg
// Shared types and constants for the wildcard byte pattern scanner.
// ---------------------------------------------------------------------------
package wbps_pkg;

	localparam int MAX_PATTERN = 16;
	localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
	localparam int POS_W       = 32;
	localparam int CFG_W       = 64;

	localparam logic [7:0] WILDCARD = 8'h2A;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_PATTERN_LOW    = 2'd0,
		CFG_PATTERN_HIGH   = 2'd1,
		CFG_PATTERN_LENGTH = 2'd2
	} cfg_index_t;

	// Byte window, entry 0 is the newest byte; also used for the pattern
	typedef logic [MAX_PATTERN-1:0][7:0] window_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} src_word_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] match_offset;
	} res_word_t;

endpackage

FILE: design/wbps_cfg_regs.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wbps_cfg_regs
// Pattern and length registers with the length clamped to the legal range.
// ---------------------------------------------------------------------------
module wbps_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  wbps_pkg::cfg_index_t                cfg_index,
	input  logic [wbps_pkg::CFG_W-1:0]          cfg_data,
	output wbps_pkg::window_t                   pattern,
	output logic [wbps_pkg::LEN_W-1:0]          active_len
);

	logic [wbps_pkg::CFG_W-1:0] pattern_low_q;
	logic [wbps_pkg::CFG_W-1:0] pattern_high_q;
	logic [4:0]                 pattern_length_q;

	// Take register writes; unknown indexes fall through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q    <= '0;
			pattern_high_q   <= '0;
			pattern_length_q <= 5'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wbps_pkg::CFG_PATTERN_LOW:    pattern_low_q    <= cfg_data;
				wbps_pkg::CFG_PATTERN_HIGH:   pattern_high_q   <= cfg_data;
				wbps_pkg::CFG_PATTERN_LENGTH: pattern_length_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	assign pattern = {pattern_high_q, pattern_low_q};

	// Clamp length: zero acts as one, anything above the window acts as full
	always_comb begin
		if (pattern_length_q == 5'd0) begin
			active_len = wbps_pkg::LEN_W'(1);
		end else if (32'(pattern_length_q) > wbps_pkg::MAX_PATTERN) begin
			active_len = wbps_pkg::LEN_W'(wbps_pkg::MAX_PATTERN);
		end else begin
			active_len = wbps_pkg::LEN_W'(pattern_length_q);
		end
	end

endmodule

FILE: design/wbps_match.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wbps_match
// Parallel compare of every window lane against its aligned pattern byte.
// ---------------------------------------------------------------------------
module wbps_match (
	input  wbps_pkg::window_t          window,
	input  wbps_pkg::window_t          pattern,
	input  logic [wbps_pkg::LEN_W-1:0] active_len,
	output logic                       hit
);

	localparam int IDX_W = $clog2(wbps_pkg::MAX_PATTERN);

	logic [wbps_pkg::MAX_PATTERN-1:0] lane_ok;

	// Window lane j lines up with pattern byte len-1-j
	for (genvar j = 0; j < wbps_pkg::MAX_PATTERN; j++) begin : g_lane
		logic [wbps_pkg::LEN_W-1:0] pat_pos;
		logic [7:0]                 pat_byte;

		assign pat_pos  = active_len - wbps_pkg::LEN_W'(1) - wbps_pkg::LEN_W'(j);
		assign pat_byte = pattern[pat_pos[IDX_W-1:0]];
		assign lane_ok[j] = (wbps_pkg::LEN_W'(j) >= active_len)
			|| (pat_byte == wbps_pkg::WILDCARD)
			|| (pat_byte == window[j]);
	end

	assign hit = &lane_ok;

endmodule

FILE: design/wbps_result_reg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wbps_result_reg
// Output register for result words, with a free flag for the scan stage.
// ---------------------------------------------------------------------------
module wbps_result_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  wbps_pkg::res_word_t load_word,
	output logic                free,
	output logic                res_valid,
	input  logic                res_stall,
	output wbps_pkg::res_word_t res_word
);

	logic                valid_q;
	wbps_pkg::res_word_t word_q;

	// Slot can take a new word when empty or being drained this cycle
	assign free = !valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	// Hold the word while stalled
	always_ff @(posedge clk) begin
		if (free && load) begin
			word_q <= load_word;
		end
	end

	assign res_valid = valid_q;
	assign res_word  = word_q;

endmodule

FILE: design/wildcard_byte_pattern_scan.sv
`timescale 1ns / 1ps
// Flow: input register, compare, result register. Throughput: one byte per cycle
// unless res_stall holds a full result register; the single compare stage between
// the input register and the result register sets this, with all lanes compared at once.
// Reset (arst_n low): window, position and match flag clear, pattern length
// returns to one and both pattern words to zero; no word is pending.
// ---------------------------------------------------------------------------
// wildcard_byte_pattern_scan
// Scans a byte stream for a wildcard pattern and reports the first match
// offset once per region, or not-found at the region's last byte.
// ---------------------------------------------------------------------------
`include "wildcard_byte_pattern_scan_defines.svh"

module wildcard_byte_pattern_scan (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [1:0]                      cfg_index,
	input  logic [wbps_pkg::CFG_W-1:0]      cfg_data,
	input  logic                            src_valid,
	output logic                            src_stall,
	input  wbps_pkg::src_word_t             src_word,
	output logic                            res_valid,
	input  logic                            res_stall,
	output wbps_pkg::res_word_t             res_word
);

	wbps_pkg::window_t          pattern;
	logic [wbps_pkg::LEN_W-1:0] active_len;

	logic                       valid_s1;
	wbps_pkg::src_word_t        word_s1;

	wbps_pkg::window_t          window_q;
	logic [wbps_pkg::POS_W-1:0] pos_q;
	logic                       reported_q;

	wbps_pkg::window_t          window_next;
	logic                       hit;
	logic                       start_ok;
	logic                       hit_new;
	logic                       miss_end;
	logic                       out_load;
	wbps_pkg::res_word_t        out_word;
	logic                       out_free;
	logic                       adv;
	logic                       accept;

	wbps_cfg_regs u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (wbps_pkg::cfg_index_t'(cfg_index)),
		.cfg_data   (cfg_data),
		.pattern    (pattern),
		.active_len (active_len)
	);

	// Input register: advance into the scan when the result slot frees up
	assign adv       = valid_s1 && out_free;
	assign src_stall = valid_s1 && !out_free;
	assign accept    = src_valid && !src_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= src_word;
		end
	end

	// Shift the newest byte into the window
	assign window_next = {window_q[wbps_pkg::MAX_PATTERN-2:0], word_s1.data_byte};

	wbps_match u_match (
		.window     (window_next),
		.pattern    (pattern),
		.active_len (active_len),
		.hit        (hit)
	);

	// Decide the result word for this byte
	always_comb begin
		start_ok = pos_q >= (wbps_pkg::POS_W'(active_len) - wbps_pkg::POS_W'(1));
		hit_new  = !reported_q && start_ok && hit;
		miss_end = word_s1.last_byte && !reported_q && !hit_new;
		out_load = adv && (hit_new || miss_end);
		out_word.found        = hit_new;
		out_word.match_offset = hit_new
			? (pos_q - (wbps_pkg::POS_W'(active_len) - wbps_pkg::POS_W'(1)))
			: '0;
	end

	// Region state: shift, count with saturation, clear at region end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q   <= '0;
			pos_q      <= '0;
			reported_q <= 1'b0;
		end else if (adv) begin
			if (word_s1.last_byte) begin
				window_q   <= '0;
				pos_q      <= '0;
				reported_q <= 1'b0;
			end else begin
				window_q   <= window_next;
				pos_q      <= (pos_q == '1) ? pos_q : pos_q + wbps_pkg::POS_W'(1);
				reported_q <= reported_q || hit_new;
			end
		end
	end

	wbps_result_reg u_res (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (out_load),
		.load_word (out_word),
		.free      (out_free),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word)
	);

	// Checks on the scan control
	`WBPS_ASSERT_NOW(a_offset_zero_on_miss, clk, arst_n,
		res_valid && !res_word.found, res_word.match_offset == '0)
	`WBPS_ASSERT_NEXT(a_region_clears, clk, arst_n,
		adv && word_s1.last_byte, pos_q == '0 && !reported_q)
	`WBPS_ASSERT_NOW(a_single_report, clk, arst_n,
		adv && reported_q, !out_load)
	`WBPS_ASSERT_NEXT(a_stall_holds_stage, clk, arst_n,
		src_stall, valid_s1)

endmodule

FILE: test/wildcard_byte_pattern_scan_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wildcard_byte_pattern_scan_checker
// Watches the configuration port and both channels of the scanner. It keeps
// its own copy of the pattern registers, the byte window and the region
// position, works out the report each accepted byte causes, and compares
// every accepted result word against the oldest outstanding report.
// ---------------------------------------------------------------------------
module wildcard_byte_pattern_scan_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [wbps_pkg::CFG_W-1:0] cfg_data,
	input  logic                       src_valid,
	input  logic                       src_stall,
	input  wbps_pkg::src_word_t        src_word,
	input  logic                       res_valid,
	input  logic                       res_stall,
	input  wbps_pkg::res_word_t        res_word,
	output int                         mismatches,
	output int                         reports_waiting,
	output int                         matches_seen,
	output int                         misses_seen
);
	import wbps_pkg::*;

	// Mirror of the pattern registers
	logic [CFG_W-1:0] pat_lo;
	logic [CFG_W-1:0] pat_hi;
	logic [4:0]       pat_len_field;

	// Mirror of the scan state
	window_t          recent;
	logic [POS_W-1:0] region_pos;
	logic             region_done;

	res_word_t        outstanding[$];
	int               err_count;
	int               hit_count;
	int               miss_count;

	// Advance the scan state by one byte and queue any report it causes
	task automatic scan_byte(input src_word_t w);
		int unsigned      len;
		int unsigned      i;
		logic [POS_W-1:0] at;
		logic             hit;
		logic             reported_now;
		window_t          pat;
		res_word_t        r;
		len = pat_len_field;
		if (len == 0)
			len = 1;
		if (len > MAX_PATTERN)
			len = MAX_PATTERN;
		pat = {pat_hi, pat_lo};
		at = region_pos;
		recent = {recent[MAX_PATTERN-2:0], w.data_byte};
		if (region_pos != '1)
			region_pos = region_pos + 1'b1;
		reported_now = 1'b0;
		// compare the newest len bytes, oldest against pattern byte 0
		if (!region_done && at >= len - 1) begin
			hit = 1'b1;
			for (i = 0; i < len; i++) begin
				if (pat[i] != WILDCARD && pat[i] != recent[len-1-i])
					hit = 1'b0;
			end
			if (hit) begin
				region_done = 1'b1;
				r.found = 1'b1;
				r.match_offset = at - (len - 1);
				outstanding.push_back(r);
				reported_now = 1'b1;
			end
		end
		// close the region, with a not-found word if nothing matched
		if (w.last_byte) begin
			if (!reported_now && !region_done) begin
				r.found = 1'b0;
				r.match_offset = '0;
				outstanding.push_back(r);
			end
			recent = '0;
			region_pos = '0;
			region_done = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_word_t want;
		if (!arst_n) begin
			pat_lo = '0;
			pat_hi = '0;
			pat_len_field = 5'd1;
			recent = '0;
			region_pos = '0;
			region_done = 1'b0;
			outstanding.delete();
			err_count = 0;
			hit_count = 0;
			miss_count = 0;
		end else begin
			// register writes; unknown indexes are dropped
			if (cfg_we) begin
				case (cfg_index)
					CFG_PATTERN_LOW:    pat_lo = cfg_data;
					CFG_PATTERN_HIGH:   pat_hi = cfg_data;
					CFG_PATTERN_LENGTH: pat_len_field = cfg_data[4:0];
					default: ;
				endcase
			end
			if (src_valid && !src_stall)
				scan_byte(src_word);
			if ($isunknown(res_valid)) begin
				$error("res_valid unknown after reset");
				err_count++;
			end
			// compare each taken result word with the oldest report
			if (res_valid && !res_stall) begin
				if (outstanding.size() == 0) begin
					$error("unexpected result word: found %0d, match_offset %0d",
						res_word.found, res_word.match_offset);
					err_count++;
				end else begin
					want = outstanding.pop_front();
					if (res_word.found !== want.found) begin
						$error("found: expected %0d, actual %0d", want.found, res_word.found);
						err_count++;
					end
					if (res_word.match_offset !== want.match_offset) begin
						$error("match_offset: expected %0d, actual %0d",
							want.match_offset, res_word.match_offset);
						err_count++;
					end
					if (want.found)
						hit_count++;
					else
						miss_count++;
				end
			end
		end
		mismatches      <= err_count;
		reports_waiting <= outstanding.size();
		matches_seen    <= hit_count;
		misses_seen     <= miss_count;
	end

endmodule

FILE: test/wildcard_byte_pattern_scan_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wildcard_byte_pattern_scan_tb
// Drives the scanner with directed regions, then with phases of random
// regions under changing patterns and lengths, with random gaps and stalls.
// The checker beside the block predicts and compares; this module gives the
// verdict.
// ---------------------------------------------------------------------------
module wildcard_byte_pattern_scan_tb;
	import wbps_pkg::*;

	localparam logic [1:0] CFG_SPARE    = 2'd3;
	localparam int         RANDOM_BYTES = 2000;
	localparam int         PHASE_BYTES  = 250;
	localparam int         QUIET_PHASE  = 3;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [1:0]       cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic             src_valid;
	logic             src_stall;
	src_word_t        src_word;
	logic             res_valid;
	logic             res_stall;
	res_word_t        res_word;

	int               mismatches;
	int               reports_waiting;
	int               matches_seen;
	int               misses_seen;

	// stimulus side copy of the pattern, used only to build matching regions
	window_t          cur_pat;
	int               cur_len;
	bit               steady_flow;
	int               bytes_sent;
	int               regions_sent;
	int               settings_used;

	wildcard_byte_pattern_scan u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_word  (src_word),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word)
	);

	wildcard_byte_pattern_scan_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.src_valid       (src_valid),
		.src_stall       (src_stall),
		.src_word        (src_word),
		.res_valid       (res_valid),
		.res_stall       (res_stall),
		.res_word        (res_word),
		.mismatches      (mismatches),
		.reports_waiting (reports_waiting),
		.matches_seen    (matches_seen),
		.misses_seen     (misses_seen)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop for a hung run
	initial begin
		#2000000;
		$display("wildcard_byte_pattern_scan verification failed");
		$finish;
	end

	// Result side back-pressure: short random stalls, none in the quiet phase
	initial begin
		int stall_left;
		res_stall = 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				res_stall <= 1'b1;
			end else if (!steady_flow && $urandom_range(99) < 2) begin
				stall_left = $urandom_range(0, 4);
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	// Offer one byte, with an occasional gap ahead of it, and hold until taken
	task automatic send_byte(input logic [7:0] b, input logic fin);
		if (!steady_flow && $urandom_range(99) < 3) begin
			src_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		src_valid <= 1'b1;
		src_word <= '{data_byte: b, last_byte: fin};
		do @(posedge clk); while (src_stall);
		bytes_sent++;
	endtask

	// Drop valid and hold until every report is back, then wait extra cycles
	task automatic drain(input int extra);
		src_valid <= 1'b0;
		@(posedge clk);
		while (reports_waiting != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	// Idle the block, then load all three pattern registers
	task automatic load_pattern(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
			input logic [4:0] len_field, input bit poke_spare);
		logic [CFG_W-1:0] len_word;
		drain(4);
		len_word = {$urandom, $urandom};
		len_word[4:0] = len_field;
		if (poke_spare)
			write_reg(CFG_SPARE, {$urandom, $urandom});
		write_reg(CFG_PATTERN_LOW, lo);
		write_reg(CFG_PATTERN_HIGH, hi);
		write_reg(CFG_PATTERN_LENGTH, len_word);
		cfg_we <= 1'b0;
		cur_pat = {hi, lo};
		cur_len = (len_field == 0) ? 1 : (len_field > MAX_PATTERN) ? MAX_PATTERN : len_field;
		settings_used++;
	endtask

	task automatic send_list(input logic [7:0] seq[$]);
		int n;
		for (n = 0; n < seq.size(); n++)
			send_byte(seq[n], n == seq.size() - 1);
		regions_sent++;
	endtask

	// One region: random lead-in, optional pattern copy (maybe spoilt), tail
	task automatic send_region(input int prefix, input bit embed, input bit spoil,
			input int suffix);
		int         n;
		int         k;
		int         total;
		int         spoilt_at;
		logic [7:0] b;
		total = prefix + (embed ? cur_len : 0) + suffix;
		spoilt_at = spoil ? $urandom_range(0, cur_len - 1) : -1;
		for (n = 0; n < total; n++) begin
			k = n - prefix;
			if (embed && k >= 0 && k < cur_len) begin
				b = (cur_pat[k] == WILDCARD) ? 8'($urandom) : cur_pat[k];
				if (k == spoilt_at)
					b = b ^ 8'($urandom_range(1, 255));
			end else begin
				b = 8'($urandom);
			end
			send_byte(b, n == total - 1);
			// now and then let the block run dry mid-region
			if (!steady_flow && n != total - 1 && $urandom_range(299) == 0)
				drain(0);
		end
		regions_sent++;
	endtask

	initial begin
		logic [7:0]       seq[$];
		logic [CFG_W-1:0] lo;
		logic [CFG_W-1:0] hi;
		logic [4:0]       len_field;
		logic [7:0]       pb;
		int               phase;
		int               phase_end;
		int               pick;
		int               lead;
		int               i;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		src_valid = 1'b0;
		src_word = '0;
		steady_flow = 1'b0;
		bytes_sent = 0;
		regions_sent = 0;
		settings_used = 1;
		cur_pat = '0;
		cur_len = 1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset pattern is a single zero byte: match on the last byte, then none
		seq = '{8'hFF, 8'h00};
		send_list(seq);
		seq = '{8'h55};
		send_list(seq);

		// Three-byte pattern with a wildcard in the middle
		load_pattern({40'h0, 8'h43, WILDCARD, 8'h41}, {CFG_W{1'b1}}, 5'd3, 1'b1);
		seq = '{8'h41, 8'h00, 8'h43};
		send_list(seq);
		// later copy after the first match must be ignored
		seq = '{8'hFF, 8'h41, 8'hFF, 8'h43, 8'h41, 8'h2A, 8'h43, 8'h00};
		send_list(seq);
		// region shorter than the pattern
		seq = '{8'h41, 8'h43};
		send_list(seq);
		seq = '{8'h41, 8'h2A, 8'h42, 8'hFF};
		send_list(seq);

		// Random phases under changing settings, extremes of length first
		phase = 0;
		phase_end = bytes_sent;
		while (bytes_sent < phase_end + RANDOM_BYTES - PHASE_BYTES || phase == 0) begin
			case (phase)
				0: len_field = 5'd16;
				1: len_field = 5'd1;
				2: len_field = 5'd0;
				3: len_field = 5'd31;
				4: len_field = 5'd17;
				default: len_field = 5'($urandom_range(0, 31));
			endcase
			for (i = 0; i < MAX_PATTERN; i++) begin
				pb = ($urandom_range(4) == 0) ? WILDCARD : 8'($urandom);
				if (phase == 6)
					pb = WILDCARD;
				if (i < 8)
					lo[8*i +: 8] = pb;
				else
					hi[8*(i-8) +: 8] = pb;
			end
			load_pattern(lo, hi, len_field, $urandom_range(3) == 0);
			steady_flow = (phase == QUIET_PHASE);
			phase_end = bytes_sent + PHASE_BYTES;
			while (bytes_sent < phase_end) begin
				pick = $urandom_range(99);
				lead = ($urandom_range(99) < 85) ? $urandom_range(0, 6) : $urandom_range(7, 40);
				if (pick < 60)
					send_region(lead, 1'b1, 1'b0,
						($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8));
				else if (pick < 75)
					send_region(lead, 1'b1, 1'b1, $urandom_range(0, 4));
				else if (pick < 90)
					send_region($urandom_range(1, 24), 1'b0, 1'b0, 0);
				else
					send_region($urandom_range(1, (cur_len > 1) ? cur_len - 1 : 1),
						1'b0, 1'b0, 0);
			end
			steady_flow = 1'b0;
			phase++;
			phase_end = bytes_sent - phase * PHASE_BYTES;
		end

		drain(8);
		$display("covered %0d bytes in %0d regions under %0d pattern settings",
			bytes_sent, regions_sent, settings_used);
		$display("checked %0d match reports and %0d not-found reports",
			matches_seen, misses_seen);
		if (mismatches == 0 && reports_waiting == 0) begin
			$display("wildcard_byte_pattern_scan verification clean");
		end else begin
			$display("wildcard_byte_pattern_scan verification failed");
		end
		$finish;
	end

endmodule
